>>> rtl/hba_pkg.sv
// ----------------------------------------------------------------------------
// hba_pkg
// Shared types and codes of the heap block allocator: transaction payloads,
// opcodes, status codes and controller states.
// ----------------------------------------------------------------------------
package hba_pkg;

    localparam int ADDR_W = 32;
    localparam int SIZE_W = 21;
    localparam logic [SIZE_W-1:0] USED_MAX = 21'h1FFFFF;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_RSVD  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_NOHEAP   = 3'd1,
        STS_ZERO     = 3'd2,
        STS_FULL     = 3'd3,
        STS_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [SIZE_W-1:0]   req_size;
        logic [ADDR_W-1:0]   block_addr;
    } in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   result_addr;
        logic [SIZE_W-1:0]   block_size;
        status_t             status;
        logic [SIZE_W-1:0]   used_bytes;
    } out_t;

endpackage

>>> rtl/heap_block_allocator.sv
// ----------------------------------------------------------------------------
// heap_block_allocator
// Bump allocator with exact-fit reuse of freed blocks. The block table sits
// in one RAM and is walked one entry per cycle for allocate, free and query.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    hba_pkg::in_t
//  m_        out        m_valid/m_ready    hba_pkg::out_t
//  cfg_      in         cfg_we             cfg_wdata (heap_base)
//
//  the table walk reads one entry per cycle through the single RAM read port,
//  covers at most block_count entries and stops at the first hit
//  zero-size and unknown-opcode transactions skip the walk
//  reset clears control state only; table entries at or above block_count are
//  never read, so the RAM needs no clearing pass
//  the result waits in an output register; a new transaction is accepted
//  while it waits, and the next result holds back until that register drains
// ----------------------------------------------------------------------------
module heap_block_allocator #(
    parameter int HEAP_BYTES   = 1048576,
    parameter int HEADER_BYTES = 8,
    parameter int MAX_BLOCKS   = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [hba_pkg::ADDR_W-1:0]  cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  hba_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output hba_pkg::out_t               m_data
);

    localparam int OFF_W   = $clog2(HEAP_BYTES);
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W  = hba_pkg::SIZE_W;
    localparam int ADDR_W  = hba_pkg::ADDR_W;
    localparam int SUM_W   = ((OFF_W > SIZE_W) ? OFF_W : SIZE_W) + 2;
    localparam int ENT_W   = OFF_W + SIZE_W + 1;
    localparam int USUM_W  = SIZE_W + 2;

    localparam logic [ADDR_W-1:0] HDR32    = ADDR_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0]  HDR_SUM  = SUM_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0]  HEAP_LIM = SUM_W'(HEAP_BYTES);
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_BLOCKS);
    localparam logic [USUM_W-1:0] HDR_USUM = USUM_W'(HEADER_BYTES);

    hba_pkg::state_t  state_reg, state_next;
    hba_pkg::opcode_t op_reg, op_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] target_reg, target_next;
    logic [SUM_W-1:0]  new_end_reg, new_end_next;
    logic [ADDR_W-1:0] new_addr_reg, new_addr_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [OFF_W-1:0]  hit_start_reg, hit_start_next;
    logic [SIZE_W-1:0] hit_len_reg, hit_len_next;
    logic              hit_busy_reg, hit_busy_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [OFF_W-1:0]  bump_reg, bump_next;
    logic [SIZE_W-1:0] used_reg, used_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              m_valid_reg, m_valid_next;
    hba_pkg::out_t     m_data_reg, m_data_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;

    logic [OFF_W-1:0]  rd_start;
    logic [SIZE_W-1:0] rd_len;
    logic              rd_busy;
    logic              scan_match;
    logic              out_free;
    logic [USUM_W-1:0] used_add_amt;
    logic [USUM_W-1:0] used_sum;
    logic [SIZE_W-1:0] used_sat;
    logic [SIZE_W-1:0] used_dec;
    logic [CNT_W-1:0]  hit_idx_inc;

    hba_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_start = ram_rdata[ENT_W-1 -: OFF_W];
    assign rd_len   = ram_rdata[SIZE_W:1];
    assign rd_busy  = ram_rdata[0];

    assign scan_match = chk_valid_reg &&
        ((op_reg == hba_pkg::OP_ALLOC) ? (!rd_busy && (rd_len == size_reg))
                                        : (ADDR_W'(rd_start) == target_reg));

    assign out_free = !m_valid_reg || m_ready;

    assign used_add_amt = hit_reg ? USUM_W'(size_reg) : (USUM_W'(size_reg) + HDR_USUM);
    assign used_sum     = USUM_W'(used_reg) + used_add_amt;
    assign used_sat     = (used_sum > USUM_W'(hba_pkg::USED_MAX)) ? hba_pkg::USED_MAX
                                                                 : used_sum[SIZE_W-1:0];
    assign used_dec     = (hit_len_reg > used_reg) ? '0 : (used_reg - hit_len_reg);
    assign hit_idx_inc  = CNT_W'(hit_idx_reg) + CNT_W'(1);

    assign s_ready = (state_reg == hba_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        target_next    = target_reg;
        new_end_next   = new_end_reg;
        new_addr_next  = new_addr_reg;
        rd_idx_next    = rd_idx_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_start_next = hit_start_reg;
        hit_len_next   = hit_len_reg;
        hit_busy_next  = hit_busy_reg;
        count_next     = count_reg;
        bump_next      = bump_reg;
        used_next      = used_reg;
        base_next      = cfg_we ? cfg_wdata : base_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = hit_idx_reg;
        ram_wdata      = {hit_start_reg, hit_len_reg, hit_busy_reg};
        ram_re         = 1'b0;
        ram_raddr      = rd_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            hba_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next       = s_data.opcode;
                    size_next     = s_data.req_size;
                    target_next   = s_data.block_addr - base_reg - HDR32;
                    new_end_next  = SUM_W'(bump_reg) + SUM_W'(s_data.req_size) + HDR_SUM;
                    new_addr_next = base_reg + ADDR_W'(bump_reg) + HDR32;
                    rd_idx_next   = '0;
                    hit_next      = 1'b0;
                    if (((s_data.opcode == hba_pkg::OP_ALLOC) && (s_data.req_size != '0)) ||
                        (s_data.opcode == hba_pkg::OP_FREE) ||
                        (s_data.opcode == hba_pkg::OP_QUERY)) begin
                        state_next = hba_pkg::ST_SCAN;
                    end else begin
                        state_next = hba_pkg::ST_FINISH;
                    end
                end
            end
            hba_pkg::ST_SCAN: begin
                if (scan_match) begin
                    hit_next       = 1'b1;
                    hit_idx_next   = chk_idx_reg;
                    hit_start_next = rd_start;
                    hit_len_next   = rd_len;
                    hit_busy_next  = rd_busy;
                    state_next     = hba_pkg::ST_FINISH;
                end else if (rd_idx_reg < count_reg) begin
                    ram_re         = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                end else begin
                    state_next = hba_pkg::ST_FINISH;
                end
            end
            hba_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.result_addr = '0;
                    m_data_next.block_size  = '0;
                    m_data_next.status      = hba_pkg::STS_OK;
                    state_next              = hba_pkg::ST_IDLE;
                    case (op_reg)
                        hba_pkg::OP_ALLOC: begin
                            if (size_reg == '0) begin
                                m_data_next.status = hba_pkg::STS_ZERO;
                            end else if (hit_reg) begin
                                ram_we    = 1'b1;
                                ram_waddr = hit_idx_reg;
                                ram_wdata = {hit_start_reg, hit_len_reg, 1'b1};
                                used_next = used_sat;
                                m_data_next.result_addr =
                                    base_reg + ADDR_W'(hit_start_reg) + HDR32;
                            end else if (new_end_reg >= HEAP_LIM) begin
                                m_data_next.status = hba_pkg::STS_NOHEAP;
                            end else if (count_reg >= CNT_MAX) begin
                                m_data_next.status = hba_pkg::STS_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[IDX_W-1:0];
                                ram_wdata  = {bump_reg, size_reg, 1'b1};
                                count_next = count_reg + CNT_W'(1);
                                bump_next  = new_end_reg[OFF_W-1:0];
                                used_next  = used_sat;
                                m_data_next.result_addr = new_addr_reg;
                            end
                        end
                        hba_pkg::OP_FREE: begin
                            if (!hit_reg) begin
                                m_data_next.status = hba_pkg::STS_NOTFOUND;
                            end else if (hit_busy_reg) begin
                                ram_we    = 1'b1;
                                ram_waddr = hit_idx_reg;
                                ram_wdata = {hit_start_reg, hit_len_reg, 1'b0};
                                used_next = used_dec;
                                if (hit_idx_inc == count_reg) begin
                                    bump_next  = hit_start_reg;
                                    count_next = CNT_W'(hit_idx_reg);
                                end
                            end
                        end
                        hba_pkg::OP_QUERY: begin
                            if (hit_reg) begin
                                m_data_next.block_size = hit_len_reg;
                            end else begin
                                m_data_next.status = hba_pkg::STS_NOTFOUND;
                            end
                        end
                        default: begin
                            m_data_next.status = hba_pkg::STS_NOTFOUND;
                        end
                    endcase
                    m_data_next.used_bytes = used_next;
                end
            end
            default: begin
                state_next = hba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hba_pkg::ST_IDLE;
            chk_valid_reg <= 1'b0;
            count_reg     <= '0;
            bump_reg      <= '0;
            used_reg      <= '0;
            base_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            count_reg     <= count_next;
            bump_reg      <= bump_next;
            used_reg      <= used_next;
            base_reg      <= base_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        size_reg      <= size_next;
        target_reg    <= target_next;
        new_end_reg   <= new_end_next;
        new_addr_reg  <= new_addr_next;
        rd_idx_reg    <= rd_idx_next;
        chk_idx_reg   <= chk_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_start_reg <= hit_start_next;
        hit_len_reg   <= hit_len_next;
        hit_busy_reg  <= hit_busy_next;
        m_data_reg    <= m_data_next;
    end

`ifndef SYNTHESIS
    a_chk_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_valid_reg |-> (state_reg == hba_pkg::ST_SCAN))
        else $error("table read in flight outside the walk");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("block count above table depth");

    a_empty_bump: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (bump_reg == '0))
        else $error("bump offset nonzero with empty table");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == hba_pkg::ST_FINISH))
        else $error("result raised outside finish");
`endif

endmodule

>>> rtl/hba_ram.sv
// ----------------------------------------------------------------------------
// hba_ram
// Generic single-clock RAM, one write port and one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module hba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
